[rtl/tosd_pkg.sv]
// shared constants and helpers for the third order multibit sigma-delta modulator
package tosd_pkg;

    localparam int ACC_W = 32;
    localparam int SUM_W = ACC_W + 3;

    typedef logic signed [ACC_W-1:0] t_acc;
    typedef logic signed [SUM_W-1:0] t_sum;

    function automatic t_acc sat_acc(input t_sum v);
        logic hi_same;
        t_acc res;
        hi_same = (v[SUM_W-1:ACC_W-1] == '0) || (v[SUM_W-1:ACC_W-1] == '1);
        if (hi_same) begin
            res = v[ACC_W-1:0];
        end else if (v[SUM_W-1]) begin
            res = {1'b1, {(ACC_W-1){1'b0}}};
        end else begin
            res = {1'b0, {(ACC_W-1){1'b1}}};
        end
        return res;
    endfunction

endpackage

[rtl/tosd_sample_if.sv]
// valid/ready channel carrying one input sample
interface tosd_sample_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

[rtl/tosd_level_if.sv]
// valid/ready channel carrying one dac level code and its clip flag
interface tosd_level_if #(
    parameter int LEVEL_BITS = 5
);
    logic                  valid;
    logic                  ready;
    logic [LEVEL_BITS-1:0] level_code;
    logic                  clipped;

    modport source (output valid, output level_code, output clipped, input ready);
    modport sink (input valid, input level_code, input clipped, output ready);
endinterface

[rtl/third_order_multibit_sigma_delta.sv]
// third order multibit sigma-delta modulator, one sample per unstalled clock
//
// usage:
//   i_smp carries one unsigned sample per oversampling tick (fraction of full
//   scale, sample / 2^SAMPLE_BITS). o_lvl returns one transaction per sample:
//   a LEVEL_BITS-bit dac level code and a flag set when the rounded level fell
//   outside 0..2^LEVEL_BITS-1 and was clamped.
//   a sample goes into an input register, the three saturating integrator
//   adds and the round/clamp run combinationally from that register, and the
//   result lands in the output register, where o_lvl.valid rises; a stalled
//   output can hold the sample in the input register between the two.
//   throughput is one sample per clock while the output is not stalled; the
//   integrator feedback loop closes through the adds and the rounder.
//   reset (synchronous, active low) clears both pipeline valids, the three
//   integrators and the fed-back level.
//   when the receiver stalls, the result holds in the output register and one
//   more sample is taken into the input register; after that i_smp.ready
//   drops until the output transaction completes.
module third_order_multibit_sigma_delta #(
    parameter int LEVEL_BITS  = 5,
    parameter int SAMPLE_BITS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    tosd_sample_if.sink  i_smp,
    tosd_level_if.source o_lvl
);

    localparam int ACC_W = tosd_pkg::ACC_W;
    localparam int SUM_W = tosd_pkg::SUM_W;
    localparam int Q_W   = ACC_W - SAMPLE_BITS;
    localparam logic [LEVEL_BITS-1:0] LMAX = '1;
    localparam logic [ACC_W:0] HALF = (ACC_W + 1)'(1) << (SAMPLE_BITS - 1);

    logic                   r_in_valid;
    logic [SAMPLE_BITS-1:0] r_sample;
    logic                   r_out_valid;
    logic [LEVEL_BITS-1:0]  r_out_level;
    logic                   r_out_clip;
    tosd_pkg::t_acc         r_acc1;
    tosd_pkg::t_acc         r_acc2;
    tosd_pkg::t_acc         r_acc3;
    logic [LEVEL_BITS-1:0]  r_fb_level;

    tosd_pkg::t_acc         n_acc1;
    tosd_pkg::t_acc         n_acc2;
    tosd_pkg::t_acc         n_acc3;
    logic [LEVEL_BITS-1:0]  n_level;
    logic                   n_clip;

    logic                   w_adv;
    logic [SUM_W-1:0]       w_x;
    logic [SUM_W-1:0]       w_fb;
    logic signed [ACC_W:0]  w_t;
    logic [Q_W-1:0]         w_q;

    assign w_adv       = r_in_valid && (!r_out_valid || o_lvl.ready);
    assign i_smp.ready = !r_in_valid || w_adv;

    // input scaled by full-scale level, feedback level aligned to the q point
    assign w_x  = SUM_W'(r_sample) * SUM_W'(LMAX);
    assign w_fb = SUM_W'(r_fb_level) << SAMPLE_BITS;

    always_comb begin
        n_acc1 = tosd_pkg::sat_acc(tosd_pkg::t_sum'(r_acc1) + $signed(w_x) - $signed(w_fb));
        n_acc2 = tosd_pkg::sat_acc(tosd_pkg::t_sum'(r_acc2) + tosd_pkg::t_sum'(n_acc1)
                                   - $signed(w_fb));
        n_acc3 = tosd_pkg::sat_acc(tosd_pkg::t_sum'(r_acc3) + tosd_pkg::t_sum'(n_acc2)
                                   - $signed(w_fb));
    end

    // round half up, then clamp to the dac range
    always_comb begin
        w_t = {n_acc3[ACC_W-1], n_acc3} + $signed(HALF);
        w_q = w_t[ACC_W-1:SAMPLE_BITS];
        if (w_t[ACC_W]) begin
            n_level = '0;
            n_clip  = 1'b1;
        end else if (w_q > Q_W'(LMAX)) begin
            n_level = LMAX;
            n_clip  = 1'b1;
        end else begin
            n_level = w_q[LEVEL_BITS-1:0];
            n_clip  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_smp.ready) begin
            r_in_valid <= i_smp.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_smp.valid && i_smp.ready) begin
            r_sample <= i_smp.sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_acc1      <= '0;
            r_acc2      <= '0;
            r_acc3      <= '0;
            r_fb_level  <= '0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
            r_acc1      <= n_acc1;
            r_acc2      <= n_acc2;
            r_acc3      <= n_acc3;
            r_fb_level  <= n_level;
        end else if (o_lvl.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_level <= n_level;
            r_out_clip  <= n_clip;
        end
    end

    assign o_lvl.valid      = r_out_valid;
    assign o_lvl.level_code = r_out_level;
    assign o_lvl.clipped    = r_out_clip;

    // feedback always matches the code just handed to the output register
    a_fb_matches_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> (r_fb_level == r_out_level))
        else $error("fed-back level differs from output code");

    // a clipped code sits on a rail
    a_clip_on_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_clip) |-> (r_out_level == '0 || r_out_level == LMAX))
        else $error("clipped code not at a rail");

    // a held input sample is not overwritten
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_adv) |=> (r_in_valid && $stable(r_sample)))
        else $error("stalled input register lost its sample");

    // no acceptance into a full input register that cannot drain
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_adv) |-> !i_smp.ready)
        else $error("input accepted while stage is blocked");

    // state only moves when a result is produced
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> ($stable(r_acc1) && $stable(r_acc3) && $stable(r_fb_level)))
        else $error("integrator state changed without a transaction");

endmodule
